/* design/kap_pkg.sv */
// Shared types, constants and helper functions for the Kaprekar step counter.
package kap_pkg;

  localparam int NumDigits = 4;
  localparam int NumCells  = 7;

  typedef logic [3:0] digit_t;
  typedef logic [NumDigits-1:0][3:0] digits_t;  // [3] is thousands, [0] is ones
  typedef logic [2:0] steps_t;

  // One word moving down the cell chain.
  typedef struct packed {
    logic    valid;
    logic    no_converge;
    steps_t  steps;
    digits_t digits;
  } kap_word_t;

  localparam logic [13:0] KapModulus   = 14'd10000;
  localparam logic [12:0] KapRecip100  = 13'd5243;   // 2^19 / 100, rounded up
  localparam int          KapShift100  = 19;
  localparam logic [13:0] KapHundred   = 14'd100;
  localparam logic [7:0]  KapRecip10   = 8'd205;     // 2^11 / 10, rounded up
  localparam int          KapShift10   = 11;
  localparam logic [6:0]  KapTen       = 7'd10;
  localparam digits_t     KapTarget    = {4'd6, 4'd1, 4'd7, 4'd4};

  // Splits a value below 100 into its tens digit (upper) and ones digit (lower).
  function automatic logic [7:0] split_two(input logic [6:0] val);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(val) * 15'(KapRecip10);
    tens = 4'(prod >> KapShift10);
    ones = val - 7'(tens) * KapTen;
    return {tens, ones[3:0]};
  endfunction

  // Ascending sort of four digits with a five compare-exchange network.
  function automatic digits_t sort_digits(input digits_t d);
    digits_t s;
    digit_t  t;
    s = d;
    if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
    if (s[2] > s[3]) begin t = s[2]; s[2] = s[3]; s[3] = t; end
    if (s[0] > s[2]) begin t = s[0]; s[0] = s[2]; s[2] = t; end
    if (s[1] > s[3]) begin t = s[1]; s[1] = s[3]; s[3] = t; end
    if (s[1] > s[2]) begin t = s[1]; s[1] = s[2]; s[2] = t; end
    return s;
  endfunction

endpackage

/* design/kap_in_if.sv */
// Input channel: one number word with a valid/ready handshake.
interface kap_in_if;
  logic        valid;
  logic        ready;
  logic [13:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

/* design/kap_out_if.sv */
// Output channel: one step count word with a valid/ready handshake.
interface kap_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] step_count;
  logic       no_converge;

  modport source (output valid, output step_count, output no_converge, input ready);
  modport sink   (input valid, input step_count, input no_converge, output ready);
endinterface

/* design/kaprekar_step_counter.sv */
// Kaprekar step counter: for a four-digit number, counts iterations until 6174 appears.
//
// The block takes one word on in_ch (number, 0 to 16383; values above 9999 are
// reduced modulo 10000) and returns one word on out_ch with step_count and
// no_converge. Numbers with four equal digits set no_converge and give zero steps.
// Both channels use valid/ready; a word moves on an edge with both high.
//
// Inside, a two-stage front end turns the number into BCD digits and flags equal
// digits, then a chain of seven identical cells each applies at most one Kaprekar
// iteration (sort, then descending minus ascending) and passes the word on.
// Each word passes the two front-end stages and then the seven cells, each a register,
// before its result shows on out_ch. The chain is fully pipelined, so a new word can
// enter every cycle while out_ch does not stall.
//
// Each stage holds its word while the next stage is full and stalled, so a stall
// on out_ch backs up only as far as the chain is full; empty stages still fill.
// Reset clears all valid flags; no result is shown until a word is accepted.
module kaprekar_step_counter (
  input  logic            clk,
  input  logic            rst,
  kap_in_if.sink          in_ch,
  kap_out_if.source       out_ch
);

  kap_pkg::kap_word_t stage [kap_pkg::NumCells+1];
  logic               take  [1:kap_pkg::NumCells+1];

  kap_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .number   (in_ch.number),
    .in_ready (in_ch.ready),
    .adv      (take[1]),
    .word     (stage[0])
  );

  for (genvar g = 0; g < kap_pkg::NumCells; g++) begin : g_cell
    kap_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (stage[g]),
      .take (take[g+1]),
      .adv  (take[g+2]),
      .word (stage[g+1])
    );
  end

  // The last cell moves on whenever the receiver is ready.
  assign take[kap_pkg::NumCells+1] = out_ch.ready;

  assign out_ch.valid       = stage[kap_pkg::NumCells].valid;
  assign out_ch.step_count  = stage[kap_pkg::NumCells].steps;
  assign out_ch.no_converge = stage[kap_pkg::NumCells].no_converge;

  // A flagged number reports no iterations.
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.no_converge |-> out_ch.step_count == 3'd0)
    else $error("flagged result with nonzero step count");

  // Every number that is not flagged has reached 6174 by the end of the chain.
  a_reached: assert property (@(posedge clk) disable iff (rst)
    stage[kap_pkg::NumCells].valid && !stage[kap_pkg::NumCells].no_converge |->
      stage[kap_pkg::NumCells].digits == kap_pkg::KapTarget)
    else $error("result leaves the chain without reaching 6174");

  // A flagged word still carries four equal digits.
  a_flag_digits: assert property (@(posedge clk) disable iff (rst)
    stage[kap_pkg::NumCells].valid && stage[kap_pkg::NumCells].no_converge |->
      (stage[kap_pkg::NumCells].digits[3] == stage[kap_pkg::NumCells].digits[2]) &&
      (stage[kap_pkg::NumCells].digits[2] == stage[kap_pkg::NumCells].digits[1]) &&
      (stage[kap_pkg::NumCells].digits[1] == stage[kap_pkg::NumCells].digits[0]))
    else $error("flag set on digits that are not all equal");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule

/* design/kap_front.sv */
// Two-stage front end: reduces the number modulo 10000 and splits it into BCD digits.
module kap_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [13:0]         number,
  output logic                in_ready,
  input  logic                adv,
  output kap_pkg::kap_word_t  word
);

  logic        s1_valid;
  logic [13:0] s1_num;
  logic [6:0]  s1_hund;
  logic        s1_take;
  logic        s2_take;

  logic [13:0] red;
  logic [26:0] prod;
  logic [13:0] rem_wide;
  logic [7:0]  hi_pair;
  logic [7:0]  lo_pair;
  kap_pkg::kap_word_t word_next;

  assign s2_take  = !word.valid || adv;
  assign s1_take  = !s1_valid || s2_take;
  assign in_ready = s1_take;

  // Inputs above 9999 are below 20000, so one subtract does the reduction.
  always_comb begin
    red  = (number >= kap_pkg::KapModulus) ? number - kap_pkg::KapModulus : number;
    prod = 27'(red) * 27'(kap_pkg::KapRecip100);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= in_valid;
      s1_num   <= red;
      s1_hund  <= 7'(prod >> kap_pkg::KapShift100);
    end
  end

  always_comb begin
    rem_wide = s1_num - 14'(s1_hund) * kap_pkg::KapHundred;
    hi_pair  = kap_pkg::split_two(s1_hund);
    lo_pair  = kap_pkg::split_two(rem_wide[6:0]);
    word_next.valid  = s1_valid;
    word_next.steps  = '0;
    word_next.digits = {hi_pair[7:4], hi_pair[3:0], lo_pair[7:4], lo_pair[3:0]};
    word_next.no_converge = (hi_pair[7:4] == hi_pair[3:0]) &&
                            (hi_pair[3:0] == lo_pair[7:4]) &&
                            (lo_pair[7:4] == lo_pair[3:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
    end else if (s2_take) begin
      word <= word_next;
    end
  end

endmodule

/* design/kap_cell.sv */
// One cell of the chain: applies a single Kaprekar iteration unless the word is finished.
module kap_cell (
  input  logic                clk,
  input  logic                rst,
  input  kap_pkg::kap_word_t  prev,
  output logic                take,
  input  logic                adv,
  output kap_pkg::kap_word_t  word
);

  kap_pkg::digits_t   sorted;
  kap_pkg::digits_t   diff;
  kap_pkg::kap_word_t word_next;
  logic               done;
  logic               borrow;
  logic [4:0]         sub;

  assign take = !word.valid || adv;
  assign done = prev.no_converge || (prev.digits == kap_pkg::KapTarget);

  // Descending arrangement minus ascending arrangement, digit by digit in BCD.
  always_comb begin
    sorted = kap_pkg::sort_digits(prev.digits);
    borrow = 1'b0;
    diff   = '0;
    for (int k = 0; k < kap_pkg::NumDigits; k++) begin
      sub = {1'b0, sorted[k]} - {1'b0, sorted[kap_pkg::NumDigits-1-k]} - 5'(borrow);
      if (sub[4]) begin
        diff[k] = 4'(sub + 5'd10);
        borrow  = 1'b1;
      end else begin
        diff[k] = sub[3:0];
        borrow  = 1'b0;
      end
    end
  end

  always_comb begin
    word_next = prev;
    if (!done) begin
      word_next.digits = diff;
      word_next.steps  = prev.steps + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
    end else if (take) begin
      word <= word_next;
    end
  end

endmodule

/* tb/kap_step_checker.sv */
`timescale 1ns / 100ps
// Watches both channels of the Kaprekar step counter, predicts each result and compares it.
module kap_step_checker (
  input  logic clk,
  input  logic rst,
  kap_in_if    in_ch,
  kap_out_if   out_ch,
  output int   fail_count,
  output int   outstanding
);

  localparam int unsigned KaprekarConst = 6174;
  localparam int unsigned StepLimit     = 7;
  localparam int unsigned DecimalSpan   = 10000;

  typedef struct packed {
    kap_pkg::steps_t step_count;
    logic            no_converge;
  } kap_result_t;

  kap_result_t expected_results[$];

  // Splits a value below 10000 into four digits, ones digit first.
  function automatic void to_digits(input int unsigned val, output int unsigned dig[4]);
    for (int i = 0; i < 4; i++) begin
      dig[i] = val % 10;
      val = val / 10;
    end
  endfunction

  function automatic kap_result_t count_kaprekar_steps(input logic [13:0] number);
    kap_result_t res;
    int unsigned val;
    int unsigned dig[4];
    int unsigned t;
    int unsigned hi;
    int unsigned lo;
    int unsigned n;
    val = int'(number) % DecimalSpan;
    to_digits(val, dig);
    if (dig[0] == dig[1] && dig[1] == dig[2] && dig[2] == dig[3]) begin
      res.step_count = '0;
      res.no_converge = 1'b1;
      return res;
    end
    n = 0;
    while (val != KaprekarConst && n < StepLimit) begin
      to_digits(val, dig);
      // Insertion sort, smallest digit ends up in dig[0].
      for (int i = 1; i < 4; i++) begin
        for (int j = i; j > 0 && dig[j-1] > dig[j]; j--) begin
          t = dig[j];
          dig[j] = dig[j-1];
          dig[j-1] = t;
        end
      end
      lo = dig[0] * 1000 + dig[1] * 100 + dig[2] * 10 + dig[3];
      hi = dig[3] * 1000 + dig[2] * 100 + dig[1] * 10 + dig[0];
      val = hi - lo;
      n++;
    end
    res.step_count = kap_pkg::steps_t'(n);
    res.no_converge = 1'b0;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    kap_result_t want;
    if (!rst) begin
      // The result side is checked before the new number is queued, so a word can
      // never be matched against an expectation raised at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no number pending: step_count %0d, no_converge %0b",
                 out_ch.step_count, out_ch.no_converge);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.step_count !== want.step_count) begin
            $error("step_count: expected %0d, actual %0d", want.step_count,
                   out_ch.step_count);
            fail_count++;
          end
          if (out_ch.no_converge !== want.no_converge) begin
            $error("no_converge: expected %0b, actual %0b", want.no_converge,
                   out_ch.no_converge);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(count_kaprekar_steps(in_ch.number));
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

/* tb/tb_kaprekar_step_counter.sv */
`timescale 1ns / 100ps
// Top of the Kaprekar step counter testbench: clock, reset, number stimulus and verdict.
module tb_kaprekar_step_counter;

  localparam int RandomPerPhase = 225;
  localparam int DrainCycles    = 30;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   stall_pct;
  int   fail_count;
  int   outstanding;

  kap_in_if  in_ch();
  kap_out_if out_ch();

  kaprekar_step_counter uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kap_step_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Edge values of the 14-bit field, every repeated digit, inputs above 9999,
  // the fixed point itself and numbers that need the full seven iterations.
  int unsigned directed_numbers[$] = '{
    0, 9999, 1111, 2222, 3333, 4444, 5555, 6666, 7777, 8888,
    6174, 16383, 10000, 11111, 16174, 8192, 1, 1112, 2111, 9998,
    6173, 1000, 2005, 3524, 12345
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: ready drops at random according to the current stall rate.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offers one number and returns once the block has accepted the word.
  task automatic send_number(input logic [13:0] number);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.number <= number;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [13:0] random_number();
    int unsigned pick;
    int unsigned rep;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // Repeated digits, sometimes pushed above 9999 so only the low digits repeat.
      rep = $urandom_range(0, 9) * 1111;
      if (rep + 10000 <= 16383 && $urandom_range(0, 1) == 1) rep = rep + 10000;
      return 14'(rep);
    end else if (pick < 14) begin
      return 14'(($urandom_range(0, 1) == 1) ? 6174 : 16174);
    end
    return 14'($urandom_range(0, 16383));
  endfunction

  initial begin
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.number  <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_numbers[i]) send_number(14'(directed_numbers[i]));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      for (int k = 0; k < RandomPerPhase; k++) send_number(random_number());
    end
    in_ch.valid <= 1'b0;

    // Waiting on the clock lets the checker count the last accepted word.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
